// ===== sv/stli_pkg.sv =====
// Shared constants, codes and types for the sample table linear interpolator.
package stli_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_DIMS_DEF    = 5;

    localparam int TIME_W    = 32;
    localparam int VAL_W     = 48;
    localparam int MAG_W     = VAL_W + 1;
    localparam int PROD_W    = MAG_W + TIME_W;
    localparam int MUL_STEPS = TIME_W;
    localparam int DIV_STEPS = MAG_W;
    localparam int STEP_W    = 6;
    localparam int OUT_COMPS = 5;
    localparam int COMP_W    = 3;
    localparam int DIMS_W    = 3;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_ORDER = 2'd3;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd5;

    typedef struct packed {
        logic [VAL_W-1:0]  vp;
        logic [VAL_W-1:0]  vn;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } lerp_req_t;

endpackage

// ===== sv/stli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/stli_lerp.sv =====
// Bit-serial interpolation unit: shift-add multiply, then restoring divide.
module stli_lerp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  stli_pkg::lerp_req_t                 req,
    output logic                                done,
    output logic [stli_pkg::VAL_W-1:0]          result
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MUL  = 4'b0010,
        L_DIV  = 4'b0100,
        L_DONE = 4'b1000
    } lstate_t;

    lstate_t                          state_reg, state_next;
    logic [stli_pkg::STEP_W-1:0]      cnt_reg, cnt_next;
    logic [stli_pkg::PROD_W-1:0]      acc_reg, acc_next;
    logic [stli_pkg::MAG_W-1:0]       mag_reg, mag_next;
    logic [stli_pkg::TIME_W-1:0]      num_reg, num_next;
    logic [stli_pkg::TIME_W-1:0]      den_reg, den_next;
    logic [stli_pkg::TIME_W-1:0]      rem_reg, rem_next;
    logic [stli_pkg::VAL_W-1:0]       p_reg, p_next;
    logic                             neg_reg, neg_next;

    logic [stli_pkg::MAG_W-1:0]       diff;
    logic [stli_pkg::MAG_W:0]         psum;
    logic [stli_pkg::TIME_W:0]        r2;
    logic                             ge;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mag_next   = mag_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        p_next     = p_reg;
        neg_next   = neg_reg;
        diff = {req.vn[stli_pkg::VAL_W-1], req.vn} - {req.vp[stli_pkg::VAL_W-1], req.vp};
        psum = {1'b0, acc_reg[stli_pkg::PROD_W-1:stli_pkg::TIME_W]}
             + (num_reg[0] ? {1'b0, mag_reg} : '0);
        r2   = {rem_reg, acc_reg[stli_pkg::MAG_W-1]};
        ge   = (r2 >= {1'b0, den_reg});
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    neg_next   = diff[stli_pkg::MAG_W-1];
                    mag_next   = diff[stli_pkg::MAG_W-1] ? (~diff + 1'b1) : diff;
                    num_next   = req.num;
                    den_next   = req.den;
                    p_next     = req.vp;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = L_MUL;
                end
            end
            L_MUL:
            begin
                acc_next = {psum, acc_reg[stli_pkg::TIME_W-1:1]};
                num_next = num_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == stli_pkg::STEP_W'(stli_pkg::MUL_STEPS - 1))
                begin
                    rem_next   = psum[stli_pkg::MAG_W:stli_pkg::MAG_W-stli_pkg::TIME_W+1];
                    cnt_next   = '0;
                    state_next = L_DIV;
                end
            end
            L_DIV:
            begin
                rem_next = ge ? stli_pkg::TIME_W'(r2 - {1'b0, den_reg})
                              : r2[stli_pkg::TIME_W-1:0];
                acc_next[stli_pkg::MAG_W-1:0] = {acc_reg[stli_pkg::MAG_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == stli_pkg::STEP_W'(stli_pkg::DIV_STEPS - 1))
                begin
                    state_next = L_DONE;
                end
            end
            L_DONE:
            begin
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mag_reg <= mag_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        p_reg   <= p_next;
        neg_reg <= neg_next;
    end

    assign done   = (state_reg == L_DONE);
    assign result = neg_reg ? (p_reg - acc_reg[stli_pkg::VAL_W-1:0])
                            : (p_reg + acc_reg[stli_pkg::VAL_W-1:0]);

endmodule

// ===== sv/sample_table_linear_interpolator_top.sv =====
// Top level of the sample table linear interpolator.
//
// Items arrive on the item channel (item_valid/item_ready) with a command:
// clear, append or query. Append and query each give one transfer on the
// result channel (result_valid/result_ready); clear gives none.
// Items are worked one at a time. Clear empties the table; append writes
// the row or sets an error status, then loads the output register. A query
// runs a binary search over the time memory, each probe a read (S_SRCH)
// and a compare (S_SCMP), then reads the row found and, when it must
// interpolate, the row before it, then runs the bit-serial interpolation
// unit once per component in use (32 multiply steps, 49 divide steps each).
// An exact hit or a query outside the table skips the interpolation and
// the second row read.
// The output register lets a new item be accepted while a result waits.
// If the receiver stalls, the next finished result holds until the output
// register is free. Reset empties the table and sets dims_in_use to five.
// dims_in_use is written over the APB port at addresses 0 to 3 (paddr[2] low).
module sample_table_linear_interpolator_top #(
    parameter int TABLE_DEPTH = stli_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_DIMS    = stli_pkg::MAX_DIMS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] time_stamp,
    input  logic signed [47:0] value_a,
    input  logic signed [47:0] value_b,
    input  logic signed [47:0] value_c,
    input  logic signed [47:0] value_d,
    input  logic signed [47:0] value_e,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  status,
    output logic signed [47:0] result_a,
    output logic signed [47:0] result_b,
    output logic signed [47:0] result_c,
    output logic signed [47:0] result_d,
    output logic signed [47:0] result_e
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int VW    = stli_pkg::VAL_W;
    localparam int RW    = VW * MAX_DIMS;
    localparam int NC    = stli_pkg::OUT_COMPS;
    localparam int PADN  = (MAX_DIMS > NC) ? MAX_DIMS : NC;
    localparam int LIM   = (MAX_DIMS < NC) ? MAX_DIMS : NC;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SRCH   = 10'b0000000010,
        S_SCMP   = 10'b0000000100,
        S_RDN    = 10'b0000001000,
        S_GOTN   = 10'b0000010000,
        S_RDP    = 10'b0000100000,
        S_GOTP   = 10'b0001000000,
        S_LSTART = 10'b0010000000,
        S_LWAIT  = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [stli_pkg::DIMS_W-1:0]   dims_cfg_reg;
    logic [stli_pkg::DIMS_W-1:0]   dims_eff;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 lo_reg, lo_next;
    logic [CW-1:0]                 hi_reg, hi_next;
    logic [CW:0]                   mid_sum;
    logic [CW-1:0]                 mid;
    logic [CW-1:0]                 rd_idx;
    logic [stli_pkg::COMP_W-1:0]   comp_reg, comp_next;
    logic                          result_valid_reg, result_valid_next;

    logic [31:0]                   last_time_reg, last_time_next;
    logic [31:0]                   ts_reg, ts_next;
    logic [31:0]                   tn_reg, tn_next;
    logic [31:0]                   tp_reg, tp_next;
    logic [RW-1:0]                 vn_row_reg, vn_row_next;
    logic [RW-1:0]                 vp_row_reg, vp_row_next;
    logic [1:0]                    work_status_reg, work_status_next;
    logic [VW-1:0]                 res_reg [NC];
    logic [VW-1:0]                 res_next [NC];
    logic [1:0]                    out_status_reg;
    logic [VW-1:0]                 out_res_reg [NC];

    logic                          accept;
    logic                          load_out;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [AW-1:0]                 ram_raddr;
    logic [RW-1:0]                 row_wdata;
    logic [31:0]                   time_rdata;
    logic [RW-1:0]                 row_rdata;
    logic [VW*PADN-1:0]            row_pad;
    logic [VW-1:0]                 in_lane [PADN];

    logic                          lerp_start;
    logic                          lerp_done;
    logic [VW-1:0]                 lerp_result;
    stli_pkg::lerp_req_t           lerp_req;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, dims_cfg_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_cfg_reg <= stli_pkg::DIMS_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            dims_cfg_reg <= pwdata[stli_pkg::DIMS_W-1:0];
        end
    end

    always_comb
    begin
        if (dims_cfg_reg == '0)
        begin
            dims_eff = stli_pkg::DIMS_W'(1);
        end
        else if (dims_cfg_reg > stli_pkg::DIMS_W'(LIM))
        begin
            dims_eff = stli_pkg::DIMS_W'(LIM);
        end
        else
        begin
            dims_eff = dims_cfg_reg;
        end
    end

    assign in_lane[0] = value_a;
    assign in_lane[1] = value_b;
    assign in_lane[2] = value_c;
    assign in_lane[3] = value_d;
    assign in_lane[4] = value_e;

    generate
        for (genvar g = NC; g < PADN; g++)
        begin : g_pad_lane
            assign in_lane[g] = '0;
        end
        for (genvar g = 0; g < MAX_DIMS; g++)
        begin : g_wrow
            assign row_wdata[g*VW +: VW] = in_lane[g];
        end
    endgenerate

    assign row_pad    = (VW*PADN)'(row_rdata);
    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign load_out   = (state_reg == S_FIN) && (!result_valid_reg || result_ready);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[CW:1];

    always_comb
    begin
        case (state_reg)
            S_SRCH:  rd_idx = mid;
            S_RDN:   rd_idx = (lo_reg == count_reg) ? (count_reg - 1'b1) : lo_reg;
            S_RDP:   rd_idx = lo_reg - 1'b1;
            default: rd_idx = '0;
        endcase
    end
    assign ram_raddr = rd_idx[AW-1:0];

    assign lerp_req.vp  = vp_row_reg[comp_reg*VW +: VW];
    assign lerp_req.vn  = vn_row_reg[comp_reg*VW +: VW];
    assign lerp_req.num = ts_reg - tp_reg;
    assign lerp_req.den = tn_reg - tp_reg;
    assign lerp_start   = (state_reg == S_LSTART);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        comp_next         = comp_reg;
        last_time_next    = last_time_reg;
        ts_next           = ts_reg;
        tn_next           = tn_reg;
        tp_next           = tp_reg;
        vn_row_next       = vn_row_reg;
        vp_row_next       = vp_row_reg;
        work_status_next  = work_status_reg;
        res_next          = res_reg;
        ram_we            = 1'b0;
        ram_waddr         = count_reg[AW-1:0];
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (load_out)
        begin
            result_valid_next = 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ts_next          = time_stamp;
                    work_status_next = stli_pkg::STATUS_OK;
                    for (int j = 0; j < NC; j++)
                    begin
                        res_next[j] = '0;
                    end
                    case (cmd)
                        stli_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        stli_pkg::CMD_APPEND:
                        begin
                            state_next = S_FIN;
                            if ((count_reg != '0) && (time_stamp == last_time_reg))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(count_reg - 1'b1);
                            end
                            else if ((count_reg != '0) && (time_stamp < last_time_reg))
                            begin
                                work_status_next = stli_pkg::STATUS_ORDER;
                            end
                            else if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                work_status_next = stli_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                last_time_next = time_stamp;
                                count_next     = count_reg + 1'b1;
                            end
                        end
                        stli_pkg::CMD_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                work_status_next = stli_pkg::STATUS_EMPTY;
                                state_next       = S_FIN;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                state_next = (lo_reg < hi_reg) ? S_SCMP : S_RDN;
                hi_next    = hi_reg;
            end
            S_SCMP:
            begin
                if (time_rdata < ts_reg)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SRCH;
            end
            S_RDN:
            begin
                state_next = S_GOTN;
            end
            S_GOTN:
            begin
                tn_next     = time_rdata;
                vn_row_next = row_rdata;
                if ((lo_reg == count_reg) || (lo_reg == '0) || (time_rdata == ts_reg))
                begin
                    for (int j = 0; j < NC; j++)
                    begin
                        res_next[j] = (stli_pkg::DIMS_W'(j) < dims_eff)
                                    ? row_pad[j*VW +: VW] : '0;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RDP;
                end
            end
            S_RDP:
            begin
                state_next = S_GOTP;
            end
            S_GOTP:
            begin
                tp_next     = time_rdata;
                vp_row_next = row_rdata;
                comp_next   = '0;
                state_next  = S_LSTART;
            end
            S_LSTART:
            begin
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (lerp_done)
                begin
                    res_next[comp_reg] = lerp_result;
                    if ((comp_reg + 1'b1) == dims_eff)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = S_LSTART;
                    end
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            comp_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            lo_reg           <= lo_next;
            hi_reg           <= hi_next;
            comp_reg         <= comp_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_time_reg   <= last_time_next;
        ts_reg          <= ts_next;
        tn_reg          <= tn_next;
        tp_reg          <= tp_next;
        vn_row_reg      <= vn_row_next;
        vp_row_reg      <= vp_row_next;
        work_status_reg <= work_status_next;
        res_reg         <= res_next;
        if (load_out)
        begin
            out_status_reg <= work_status_reg;
            out_res_reg    <= res_reg;
        end
    end

    stli_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_time_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ts_next),
        .raddr (ram_raddr),
        .rdata (time_rdata)
    );

    stli_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (row_wdata),
        .raddr (ram_raddr),
        .rdata (row_rdata)
    );

    stli_lerp u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lerp_start),
        .req    (lerp_req),
        .done   (lerp_done),
        .result (lerp_result)
    );

    assign result_valid = result_valid_reg;
    assign status       = out_status_reg;
    assign result_a     = out_res_reg[0];
    assign result_b     = out_res_reg[1];
    assign result_c     = out_res_reg[2];
    assign result_d     = out_res_reg[3];
    assign result_e     = out_res_reg[4];

endmodule

// ===== sv/stli_checker.sv =====
// Port-level checker for the sample table linear interpolator, with its bind.
module stli_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        item_valid,
    input logic        item_ready,
    input logic [1:0]  cmd,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  status,
    input logic [47:0] result_a,
    input logic [47:0] result_b,
    input logic [47:0] result_c,
    input logic [47:0] result_d,
    input logic [47:0] result_e
);

    // A stalled result keeps its status.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status))
        else $error("Stalled result changed.");

    // A clear transfer never produces a result.
    a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (cmd == stli_pkg::CMD_CLEAR) && !result_valid
        |=> !result_valid)
        else $error("Clear produced a result.");

    // Every result with an error status carries zero components.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != stli_pkg::STATUS_OK)
        |-> (result_a == '0) && (result_b == '0) && (result_c == '0)
            && (result_d == '0) && (result_e == '0))
        else $error("Nonzero components with an error status.");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped.");

endmodule

bind sample_table_linear_interpolator_top stli_checker u_stli_checker (.*);
